@@ hw/rtl/bagm_pkg.sv @@
// Shared constants, types and the glyph lookup for the box-average glyph mapper.
package bagm_pkg;

  localparam int MAX_IMAGE_WIDTH_DEF = 4096;
  localparam int MAX_SCALE_DEF       = 8;
  localparam int MAX_IMAGE_HEIGHT    = 4096;

  localparam int PIXEL_W    = 8;
  localparam int GLYPH_W    = 7;
  localparam int CELL_COL_W = 12;
  localparam int CELL_ROW_W = 11;
  localparam int Y_W        = 12;
  localparam int DIM_W      = 13;
  localparam int SCALE_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int LUMA_FULL = 255;
  localparam int RAMP_TOP  = 9;

  localparam logic [DIM_W-1:0]   IMAGE_WIDTH_RST  = 13'd240;
  localparam logic [DIM_W-1:0]   IMAGE_HEIGHT_RST = 13'd180;
  localparam logic [SCALE_W-1:0] CELL_SCALE_RST   = 4'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_CELL_SCALE   = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_HOLD
  } div_state_t;

  // Where the current pixel sits inside its cell and the frame.
  typedef struct packed {
    logic col_end;
    logic last_row;
    logic line_end;
    logic frame_end;
    logic rib_zero;
  } cell_flags_t;

  // Brightness ramp " .:*coCO?@"
  localparam logic [GLYPH_W-1:0] GLYPH_RAMP [RAMP_TOP+1] = '{
    7'd32, 7'd46, 7'd58, 7'd42, 7'd99, 7'd111, 7'd67, 7'd79, 7'd63, 7'd64
  };

  // index = avg*9/255, found by comparing against each step threshold
  function automatic logic [GLYPH_W-1:0] glyph_of(input logic [PIXEL_W-1:0] avg);
    logic [11:0] scaled;
    logic [3:0]  idx;
    scaled = 12'(avg) * 12'(RAMP_TOP);
    idx    = '0;
    for (int k = 1; k <= RAMP_TOP; k++) begin
      if (scaled >= 12'(k * LUMA_FULL)) idx = 4'(k);
    end
    return GLYPH_RAMP[idx];
  endfunction

endpackage

@@ hw/rtl/box_average_glyph_mapper.sv @@
// Top level: config registers, column-sum memory read-modify-write, divider hookup.
// Path: a cell's sum is registered in the memory stage, then divided and registered at the output.
// Throughput: pixels that close no cell on a band's last row go in every cycle while the divider
//   is idle and no rederive runs; a pixel that does holds the input until the 8-step divider is done.
// Config write: input holds while the position divider rederives cell position.
// Reset: position counters clear, registers load 240 x 180 with scale 2; column sums are not cleared.
module box_average_glyph_mapper #(
  parameter  int MAX_IMAGE_WIDTH = bagm_pkg::MAX_IMAGE_WIDTH_DEF,
  parameter  int MAX_SCALE       = bagm_pkg::MAX_SCALE_DEF,
  localparam int XW = $clog2(MAX_IMAGE_WIDTH)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bagm_pkg::PIXEL_W-1:0]        in_pixel,
  input  logic                                in_frame_start,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bagm_pkg::GLYPH_W-1:0]        out_glyph,
  output logic [bagm_pkg::CELL_COL_W-1:0]     out_cell_column,
  output logic [bagm_pkg::CELL_ROW_W-1:0]     out_cell_row,
  output logic                                out_line_end,
  output logic                                out_frame_end,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bagm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bagm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import bagm_pkg::*;

  localparam int CW   = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
  localparam int RW   = $clog2(2 * MAX_SCALE);
  localparam int SCW  = $clog2(MAX_SCALE + 1);
  localparam int RSW  = $clog2(MAX_SCALE * 255 + 1);
  localparam int SUMW = $clog2(2 * MAX_SCALE * MAX_SCALE * 255 + 1);
  localparam int CNTW = $clog2(2 * MAX_SCALE * MAX_SCALE + 1);

  logic [DIM_W-1:0]   iw_r, iw_nxt, ih_r, ih_nxt;
  logic [SCALE_W-1:0] sc_r, sc_nxt;
  logic [XW:0]        w_eff;
  logic [DIM_W-1:0]   h_eff;
  logic [SCW-1:0]     s_eff;
  logic               cfg_wr;

  logic [XW-1:0]         cur_cx;
  logic [CELL_ROW_W-1:0] cur_cy;
  logic [CW-1:0]         cur_cic;
  logic [RW-1:0]         cur_rib;
  cell_flags_t           flags;
  logic                  fix_busy;

  logic take, rd_en, div_busy, div_start;

  logic [RSW-1:0]  rs_r, rs_nxt, rs_sum;
  logic [CW:0]     cic_p1;
  logic [RW:0]     rib_p1;
  logic [CNTW-1:0] count;

  logic                  b_valid_r, b_valid_nxt, b_last_r, b_last_nxt;
  logic [RSW-1:0]        b_rs_r, b_rs_nxt;
  logic [XW-1:0]         b_addr_r, b_addr_nxt;
  logic                  b_rib0_r, b_rib0_nxt;
  logic [CNTW-1:0]       b_count_r, b_count_nxt;
  logic [CELL_ROW_W-1:0] b_cy_r, b_cy_nxt;
  logic                  b_le_r, b_le_nxt, b_fe_r, b_fe_nxt;
  logic                  b_fwd_r, b_fwd_nxt;
  logic [SUMW-1:0]       b_fwd_data_r, b_fwd_data_nxt;
  logic [SUMW-1:0]       rd_data, b_old, b_total;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    iw_nxt = iw_r;
    ih_nxt = ih_r;
    sc_nxt = sc_r;
    if (cfg_wr) begin
      case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:  iw_nxt = cfg_data;
        CFG_IMAGE_HEIGHT: ih_nxt = cfg_data;
        CFG_CELL_SCALE:   sc_nxt = cfg_data[SCALE_W-1:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iw_r <= IMAGE_WIDTH_RST;
      ih_r <= IMAGE_HEIGHT_RST;
      sc_r <= CELL_SCALE_RST;
    end else begin
      iw_r <= iw_nxt;
      ih_r <= ih_nxt;
      sc_r <= sc_nxt;
    end
  end

  // zero acts as one, oversize saturates at the maximum
  always_comb begin
    if (iw_r == '0) w_eff = (XW+1)'(1);
    else if (int'(iw_r) > MAX_IMAGE_WIDTH) w_eff = (XW+1)'(MAX_IMAGE_WIDTH);
    else w_eff = (XW+1)'(iw_r);
    if (ih_r == '0) h_eff = DIM_W'(1);
    else if (int'(ih_r) > MAX_IMAGE_HEIGHT) h_eff = DIM_W'(MAX_IMAGE_HEIGHT);
    else h_eff = ih_r;
    if (sc_r == '0) s_eff = SCW'(1);
    else if (int'(sc_r) > MAX_SCALE) s_eff = SCW'(MAX_SCALE);
    else s_eff = SCW'(sc_r);
  end

  bagm_pos #(
    .MAX_IMAGE_WIDTH(MAX_IMAGE_WIDTH),
    .MAX_SCALE      (MAX_SCALE)
  ) u_pos (
    .clk        (clk),
    .rst_n      (rst_n),
    .w_eff      (w_eff),
    .h_eff      (h_eff),
    .s_eff      (s_eff),
    .fix_start  (cfg_wr),
    .take       (take),
    .frame_start(in_frame_start),
    .cur_cx     (cur_cx),
    .cur_cy     (cur_cy),
    .cur_cic    (cur_cic),
    .cur_rib    (cur_rib),
    .flags      (flags),
    .fix_busy   (fix_busy)
  );

  // hold input while the divider is loaded or busy, or positions are rederived
  assign div_start = b_valid_r && b_last_r;
  assign in_stall  = fix_busy || div_busy || div_start;
  assign take      = in_valid && !in_stall;
  assign rd_en     = take && flags.col_end && !flags.rib_zero;

  always_comb begin
    rs_sum = ((cur_cic == '0) ? RSW'(0) : rs_r) + RSW'(in_pixel);
    cic_p1 = {1'b0, cur_cic} + 1'b1;
    rib_p1 = {1'b0, cur_rib} + 1'b1;
    count  = CNTW'(cic_p1) * CNTW'(rib_p1);
  end

  // memory stage: the previous word writes the same column this cycle, forward it
  always_comb begin
    b_old   = b_rib0_r ? SUMW'(0) : (b_fwd_r ? b_fwd_data_r : rd_data);
    b_total = b_old + SUMW'(b_rs_r);
  end

  always_comb begin
    rs_nxt         = rs_r;
    b_valid_nxt    = 1'b0;
    b_last_nxt     = 1'b0;
    b_rs_nxt       = b_rs_r;
    b_addr_nxt     = b_addr_r;
    b_rib0_nxt     = b_rib0_r;
    b_count_nxt    = b_count_r;
    b_cy_nxt       = b_cy_r;
    b_le_nxt       = b_le_r;
    b_fe_nxt       = b_fe_r;
    b_fwd_nxt      = b_fwd_r;
    b_fwd_data_nxt = b_fwd_data_r;
    if (take) begin
      rs_nxt = rs_sum;
      if (flags.col_end) begin
        b_valid_nxt    = 1'b1;
        b_last_nxt     = flags.last_row;
        b_rs_nxt       = rs_sum;
        b_addr_nxt     = cur_cx;
        b_rib0_nxt     = flags.rib_zero;
        b_count_nxt    = count;
        b_cy_nxt       = cur_cy;
        b_le_nxt       = flags.line_end;
        b_fe_nxt       = flags.frame_end;
        b_fwd_nxt      = b_valid_r && (b_addr_r == cur_cx);
        b_fwd_data_nxt = b_total;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_r      <= '0;
      b_valid_r <= 1'b0;
      b_last_r  <= 1'b0;
    end else begin
      rs_r      <= rs_nxt;
      b_valid_r <= b_valid_nxt;
      b_last_r  <= b_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_rs_r       <= b_rs_nxt;
    b_addr_r     <= b_addr_nxt;
    b_rib0_r     <= b_rib0_nxt;
    b_count_r    <= b_count_nxt;
    b_cy_r       <= b_cy_nxt;
    b_le_r       <= b_le_nxt;
    b_fe_r       <= b_fe_nxt;
    b_fwd_r      <= b_fwd_nxt;
    b_fwd_data_r <= b_fwd_data_nxt;
  end

  bagm_ram #(
    .WIDTH(SUMW),
    .DEPTH(MAX_IMAGE_WIDTH)
  ) u_col_sums (
    .clk    (clk),
    .we     (b_valid_r),
    .waddr  (b_addr_r),
    .wdata  (b_total),
    .re     (rd_en),
    .raddr  (cur_cx),
    .rd_data(rd_data)
  );

  bagm_div #(
    .MAX_IMAGE_WIDTH(MAX_IMAGE_WIDTH),
    .MAX_SCALE      (MAX_SCALE)
  ) u_div (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (div_start),
    .total          (b_total),
    .count          (b_count_r),
    .cx             (b_addr_r),
    .cy             (b_cy_r),
    .le             (b_le_r),
    .fe             (b_fe_r),
    .busy           (div_busy),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_glyph      (out_glyph),
    .out_cell_column(out_cell_column),
    .out_cell_row   (out_cell_row),
    .out_line_end   (out_line_end),
    .out_frame_end  (out_frame_end)
  );

`ifndef SYNTHESIS
  a_div_free_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("cell sum handed to a busy divider");

  a_same_column_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (take && flags.col_end && b_valid_r && (b_addr_r == cur_cx)) |=> b_fwd_r)
    else $error("back-to-back column update missed forwarding");
`endif

endmodule

@@ hw/rtl/bagm_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module bagm_ram #(
  parameter  int WIDTH = 16,
  parameter  int DEPTH = 256,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // read-first: a same-cycle write is not seen by the read
  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    if (re) rd_data_r <= mem_r[raddr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/bagm_pos.sv @@
// Raster position tracking and cell coordinates, with a recompute divider after config writes.
module bagm_pos #(
  parameter  int MAX_IMAGE_WIDTH = 4096,
  parameter  int MAX_SCALE       = 8,
  localparam int XW  = $clog2(MAX_IMAGE_WIDTH),
  localparam int CW  = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1,
  localparam int RW  = $clog2(2 * MAX_SCALE),
  localparam int SCW = $clog2(MAX_SCALE + 1),
  localparam int BW  = SCW + 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [XW:0]                         w_eff,
  input  logic [bagm_pkg::DIM_W-1:0]          h_eff,
  input  logic [SCW-1:0]                      s_eff,
  input  logic                                fix_start,
  input  logic                                take,
  input  logic                                frame_start,
  output logic [XW-1:0]                       cur_cx,
  output logic [bagm_pkg::CELL_ROW_W-1:0]     cur_cy,
  output logic [CW-1:0]                       cur_cic,
  output logic [RW-1:0]                       cur_rib,
  output bagm_pkg::cell_flags_t               flags,
  output logic                                fix_busy
);
  import bagm_pkg::*;

  localparam int FN  = (XW > Y_W) ? XW : Y_W;
  localparam int FCW = $clog2(FN + 1);

  logic [XW-1:0]         x_r, x_nxt;
  logic [Y_W-1:0]        y_r, y_nxt;
  logic [XW-1:0]         cx_r, cx_nxt;
  logic [CELL_ROW_W-1:0] cy_r, cy_nxt;
  logic [CW-1:0]         cic_r, cic_nxt;
  logic [RW-1:0]         rib_r, rib_nxt;
  logic [FCW-1:0]        fcnt_r, fcnt_nxt;

  logic [FN-1:0] fxd_r, fxd_nxt, fyd_r, fyd_nxt;
  logic [FN-1:0] fxq_r, fxq_nxt, fyq_r, fyq_nxt;
  logic [BW-1:0] fxr_r, fxr_nxt, fyr_r, fyr_nxt;

  logic [BW-1:0] band;
  logic [XW-1:0] cur_x;
  logic [Y_W-1:0] cur_y;
  logic [Y_W:0]  y_mid;
  logic          le, yl, cic_last, rib_last;

  logic [BW:0]   xtr, ytr;
  logic [BW-1:0] xrem, yrem;
  logic          xbit, ybit;

  assign band     = {s_eff, 1'b0};
  assign fix_busy = (fcnt_r != '0);

  // position of this pixel: frame start clears, a stale column or row wraps
  always_comb begin
    cur_x   = x_r;
    cur_y   = y_r;
    cur_cx  = cx_r;
    cur_cy  = cy_r;
    cur_cic = cic_r;
    cur_rib = rib_r;
    if (frame_start) begin
      cur_x   = '0;
      cur_y   = '0;
      cur_cx  = '0;
      cur_cy  = '0;
      cur_cic = '0;
      cur_rib = '0;
    end
    y_mid = {1'b0, cur_y};
    if ({1'b0, cur_x} >= w_eff) begin
      cur_x   = '0;
      cur_cx  = '0;
      cur_cic = '0;
      y_mid   = {1'b0, cur_y} + 1'b1;
      if (BW'(cur_rib) == band - 1'b1) begin
        cur_rib = '0;
        cur_cy  = cur_cy + 1'b1;
      end else begin
        cur_rib = cur_rib + 1'b1;
      end
    end
    if (y_mid >= h_eff) begin
      cur_y   = '0;
      cur_rib = '0;
      cur_cy  = '0;
    end else begin
      cur_y = y_mid[Y_W-1:0];
    end
  end

  always_comb begin
    le       = ({1'b0, cur_x} == w_eff - 1'b1);
    yl       = ({1'b0, cur_y} == h_eff - 1'b1);
    cic_last = (SCW'(cur_cic) == s_eff - 1'b1);
    rib_last = (BW'(cur_rib) == band - 1'b1);
    flags.col_end   = cic_last || le;
    flags.last_row  = rib_last || yl;
    flags.line_end  = le;
    flags.frame_end = le && yl;
    flags.rib_zero  = (cur_rib == '0);
  end

  // one quotient bit of x / s and y / band per cycle
  always_comb begin
    xtr = {fxr_r, fxd_r[FN-1]};
    if (xtr >= (BW+1)'(s_eff)) begin
      xrem = BW'(xtr - (BW+1)'(s_eff));
      xbit = 1'b1;
    end else begin
      xrem = BW'(xtr);
      xbit = 1'b0;
    end
    ytr = {fyr_r, fyd_r[FN-1]};
    if (ytr >= (BW+1)'(band)) begin
      yrem = BW'(ytr - (BW+1)'(band));
      ybit = 1'b1;
    end else begin
      yrem = BW'(ytr);
      ybit = 1'b0;
    end
  end

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    cx_nxt   = cx_r;
    cy_nxt   = cy_r;
    cic_nxt  = cic_r;
    rib_nxt  = rib_r;
    fcnt_nxt = fcnt_r;
    fxd_nxt  = fxd_r;
    fyd_nxt  = fyd_r;
    fxq_nxt  = fxq_r;
    fyq_nxt  = fyq_r;
    fxr_nxt  = fxr_r;
    fyr_nxt  = fyr_r;
    if (fix_start) begin
      fxd_nxt  = FN'(x_r);
      fyd_nxt  = FN'(y_r);
      fxq_nxt  = '0;
      fyq_nxt  = '0;
      fxr_nxt  = '0;
      fyr_nxt  = '0;
      fcnt_nxt = FCW'(FN);
    end else if (fix_busy) begin
      fxd_nxt  = fxd_r << 1;
      fyd_nxt  = fyd_r << 1;
      fxq_nxt  = {fxq_r[FN-2:0], xbit};
      fyq_nxt  = {fyq_r[FN-2:0], ybit};
      fxr_nxt  = xrem;
      fyr_nxt  = yrem;
      fcnt_nxt = fcnt_r - 1'b1;
      if (fcnt_r == FCW'(1)) begin
        cx_nxt  = XW'({fxq_r[FN-2:0], xbit});
        cic_nxt = CW'(xrem);
        cy_nxt  = CELL_ROW_W'({fyq_r[FN-2:0], ybit});
        rib_nxt = RW'(yrem);
      end
    end else if (take) begin
      if (le) begin
        x_nxt   = '0;
        cx_nxt  = '0;
        cic_nxt = '0;
        if (yl) begin
          y_nxt   = '0;
          rib_nxt = '0;
          cy_nxt  = '0;
        end else begin
          y_nxt = cur_y + 1'b1;
          if (rib_last) begin
            rib_nxt = '0;
            cy_nxt  = cur_cy + 1'b1;
          end else begin
            rib_nxt = cur_rib + 1'b1;
            cy_nxt  = cur_cy;
          end
        end
      end else begin
        x_nxt  = cur_x + 1'b1;
        y_nxt  = cur_y;
        cy_nxt = cur_cy;
        rib_nxt = cur_rib;
        if (cic_last) begin
          cic_nxt = '0;
          cx_nxt  = cur_cx + 1'b1;
        end else begin
          cic_nxt = cur_cic + 1'b1;
          cx_nxt  = cur_cx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r    <= '0;
      y_r    <= '0;
      cx_r   <= '0;
      cy_r   <= '0;
      cic_r  <= '0;
      rib_r  <= '0;
      fcnt_r <= '0;
    end else begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      cx_r   <= cx_nxt;
      cy_r   <= cy_nxt;
      cic_r  <= cic_nxt;
      rib_r  <= rib_nxt;
      fcnt_r <= fcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fxd_r <= fxd_nxt;
    fyd_r <= fyd_nxt;
    fxq_r <= fxq_nxt;
    fyq_r <= fyq_nxt;
    fxr_r <= fxr_nxt;
    fyr_r <= fyr_nxt;
  end

`ifndef SYNTHESIS
  a_cic_in_cell: assert property (@(posedge clk) disable iff (!rst_n)
    !fix_busy |-> (SCW'(cic_r) < s_eff))
    else $error("column-in-cell counter out of range");

  a_rib_in_band: assert property (@(posedge clk) disable iff (!rst_n)
    !fix_busy |-> (BW'(rib_r) < band))
    else $error("row-in-band counter out of range");
`endif

endmodule

@@ hw/rtl/bagm_div.sv @@
// Cell average divider, glyph lookup and output register.
module bagm_div #(
  parameter  int MAX_IMAGE_WIDTH = 4096,
  parameter  int MAX_SCALE       = 8,
  localparam int XW   = $clog2(MAX_IMAGE_WIDTH),
  localparam int SUMW = $clog2(2 * MAX_SCALE * MAX_SCALE * 255 + 1),
  localparam int CNTW = $clog2(2 * MAX_SCALE * MAX_SCALE + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [SUMW-1:0]                   total,
  input  logic [CNTW-1:0]                   count,
  input  logic [XW-1:0]                     cx,
  input  logic [bagm_pkg::CELL_ROW_W-1:0]   cy,
  input  logic                              le,
  input  logic                              fe,
  output logic                              busy,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [bagm_pkg::GLYPH_W-1:0]      out_glyph,
  output logic [bagm_pkg::CELL_COL_W-1:0]   out_cell_column,
  output logic [bagm_pkg::CELL_ROW_W-1:0]   out_cell_row,
  output logic                              out_line_end,
  output logic                              out_frame_end
);
  import bagm_pkg::*;

  localparam int DW  = CNTW + PIXEL_W - 1;
  localparam int MW  = (SUMW > DW) ? SUMW : DW;
  localparam int STW = $clog2(PIXEL_W);

  div_state_t state_r, state_nxt;

  logic [SUMW-1:0]       rem_r, rem_nxt;
  logic [DW-1:0]         den_r, den_nxt;
  logic [PIXEL_W-1:0]    quot_r, quot_nxt;
  logic [STW-1:0]        step_r, step_nxt;
  logic [XW-1:0]         cx_r, cx_nxt;
  logic [CELL_ROW_W-1:0] cy_r, cy_nxt;
  logic                  le_r, le_nxt, fe_r, fe_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [GLYPH_W-1:0]    glyph_r, glyph_nxt;
  logic [CELL_COL_W-1:0] col_r, col_nxt;
  logic [CELL_ROW_W-1:0] row_r, row_nxt;
  logic                  ole_r, ole_nxt, ofe_r, ofe_nxt;

  logic out_free, run, load_out, ge;

  assign out_free = !out_valid_r || !out_stall;
  assign ge       = (MW'(rem_r) >= MW'(den_r));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      DIV_IDLE: if (start) state_nxt = DIV_RUN;
      DIV_RUN:  if (step_r == '0) state_nxt = DIV_HOLD;
      DIV_HOLD: if (out_free) state_nxt = DIV_IDLE;
      default:  state_nxt = DIV_IDLE;
    endcase
  end

  always_comb begin
    busy     = 1'b1;
    run      = 1'b0;
    load_out = 1'b0;
    case (state_r)
      DIV_IDLE: busy = 1'b0;
      DIV_RUN:  run = 1'b1;
      DIV_HOLD: load_out = out_free;
      default:  busy = 1'b0;
    endcase
  end

  // restoring division: the average is below 256, so eight steps suffice
  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;
    step_nxt = step_r;
    cx_nxt   = cx_r;
    cy_nxt   = cy_r;
    le_nxt   = le_r;
    fe_nxt   = fe_r;
    if (start && !busy) begin
      rem_nxt  = total;
      den_nxt  = DW'(count) << (PIXEL_W - 1);
      quot_nxt = '0;
      step_nxt = STW'(PIXEL_W - 1);
      cx_nxt   = cx;
      cy_nxt   = cy;
      le_nxt   = le;
      fe_nxt   = fe;
    end else if (run) begin
      if (ge) rem_nxt = SUMW'(MW'(rem_r) - MW'(den_r));
      quot_nxt = {quot_r[PIXEL_W-2:0], ge};
      den_nxt  = den_r >> 1;
      step_nxt = step_r - 1'b1;
    end
  end

  always_comb begin
    glyph_nxt     = glyph_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    ole_nxt       = ole_r;
    ofe_nxt       = ofe_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      glyph_nxt     = glyph_of(quot_r);
      col_nxt       = CELL_COL_W'(cx_r);
      row_nxt       = cy_r;
      ole_nxt       = le_r;
      ofe_nxt       = fe_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= DIV_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    den_r   <= den_nxt;
    quot_r  <= quot_nxt;
    step_r  <= step_nxt;
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    le_r    <= le_nxt;
    fe_r    <= fe_nxt;
    glyph_r <= glyph_nxt;
    col_r   <= col_nxt;
    row_r   <= row_nxt;
    ole_r   <= ole_nxt;
    ofe_r   <= ofe_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_glyph       = glyph_r;
  assign out_cell_column = col_r;
  assign out_cell_row    = row_r;
  assign out_line_end    = ole_r;
  assign out_frame_end   = ofe_r;

`ifndef SYNTHESIS
  a_out_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == DIV_HOLD))
    else $error("output word raised without a finished division");
`endif

endmodule

@@ sim/box_average_glyph_mapper_tb.sv @@
// Self-checking bench for the box-average glyph mapper: power-up frame, directed table, size extremes, random frames.
`timescale 1ns / 100ps

module box_average_glyph_mapper_tb;
  import bagm_pkg::*;

  localparam int          RANDOM_PIXELS = 2000;
  localparam int unsigned CYCLE_CAP     = 3_000_000;
  localparam int          SETTLE_CYCLES = 30;

  typedef struct packed {
    logic [GLYPH_W-1:0]    glyph;
    logic [CELL_COL_W-1:0] cell_column;
    logic [CELL_ROW_W-1:0] cell_row;
    logic                  line_end;
    logic                  frame_end;
  } glyph_word_t;

  typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

  typedef enum int {LUMA_NOISE, LUMA_RAILS, LUMA_FLAT, LUMA_EDGE} luma_mode_t;

  // One line of the directed script; idx/val only matter on register rows.
  typedef struct packed {
    row_kind_t           kind;
    cfg_idx_t            idx;
    logic [DIM_W-1:0]    val;
    logic [PIXEL_W-1:0]  luma;
    logic                fs;
    logic                known;
    glyph_word_t         want;
  } step_row_t;

  localparam glyph_word_t NO_WORD = '0;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PIXEL_W-1:0]    in_pixel = '0;
  logic                  in_frame_start = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [GLYPH_W-1:0]    out_glyph;
  logic [CELL_COL_W-1:0] out_cell_column;
  logic [CELL_ROW_W-1:0] out_cell_row;
  logic                  out_line_end;
  logic                  out_frame_end;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index = CFG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  box_average_glyph_mapper dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pixel        (in_pixel),
    .in_frame_start  (in_frame_start),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_glyph       (out_glyph),
    .out_cell_column (out_cell_column),
    .out_cell_row    (out_cell_row),
    .out_line_end    (out_line_end),
    .out_frame_end   (out_frame_end),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  // Mirror of the block's registers and accumulation state.
  logic [DIM_W-1:0]   width_reg  = IMAGE_WIDTH_RST;
  logic [DIM_W-1:0]   height_reg = IMAGE_HEIGHT_RST;
  logic [SCALE_W-1:0] scale_reg  = CELL_SCALE_RST;
  logic [14:0]        band_sums [4096];
  logic [12:0]        at_x = '0;
  logic [12:0]        at_y = '0;
  logic [14:0]        row_acc = '0;
  string              glyph_set = " .:*coCO?@";

  glyph_word_t glyphs_due [$];
  glyph_word_t due_head;

  int          pixels_sent   = 0;
  int          words_checked = 0;
  int          fault_count   = 0;
  int          settings_seen = 0;
  int unsigned cycle_count   = 0;
  bit          quiet         = 1'b0;
  int          stall_left    = 0;

  step_row_t script [36] = '{
    '{ROW_CFG, CFG_IMAGE_WIDTH,  13'd1, 8'd0, 1'b0, 1'b0, NO_WORD},
    '{ROW_CFG, CFG_IMAGE_HEIGHT, 13'd1, 8'd0, 1'b0, 1'b0, NO_WORD},
    '{ROW_CFG, CFG_CELL_SCALE,   13'd1, 8'd0, 1'b0, 1'b0, NO_WORD},
    // one-pixel cells: every pixel is a word, darkest and brightest
    '{ROW_PIX, CFG_IMAGE_WIDTH, 13'd0, 8'd0,   1'b1, 1'b1, '{7'h20, 12'd0, 11'd0, 1'b1, 1'b1}},
    '{ROW_PIX, CFG_IMAGE_WIDTH, 13'd0, 8'd255, 1'b0, 1'b1, '{7'h40, 12'd0, 11'd0, 1'b1, 1'b1}},
    // straddle the first two ramp steps and the top one
    '{ROW_PIX, CFG_IMAGE_WIDTH, 13'd0, 8'd28,  1'b0, 1'b0, NO_WORD},
    '{ROW_PIX, CFG_IMAGE_WIDTH, 13'd0, 8'd29,  1'b0, 1'b0, NO_WORD},
    '{ROW_PIX, CFG_IMAGE_WIDTH, 13'd0, 8'd56,  1'b0, 1'b0, NO_WORD},
    '{ROW_PIX, CFG_IMAGE_WIDTH, 13'd0, 8'd57,  1'b0, 1'b0, NO_WORD},
    '{ROW_PIX, CFG_IMAGE_WIDTH, 13'd0, 8'd254, 1'b0, 1'b0, NO_WORD},
    // zero registers act as one
    '{ROW_CFG, CFG_IMAGE_WIDTH,  13'd0, 8'd0, 1'b0, 1'b0, NO_WORD},
    '{ROW_CFG, CFG_IMAGE_HEIGHT, 13'd0, 8'd0, 1'b0, 1'b0, NO_WORD},
    '{ROW_CFG, CFG_CELL_SCALE,   13'd0, 8'd0, 1'b0, 1'b0, NO_WORD},
    '{ROW_PIX, CFG_IMAGE_WIDTH, 13'd0, 8'd255, 1'b1, 1'b1, '{7'h40, 12'd0, 11'd0, 1'b1, 1'b1}},
    '{ROW_PIX, CFG_IMAGE_WIDTH, 13'd0, 8'd0,   1'b0, 1'b1, '{7'h20, 12'd0, 11'd0, 1'b1, 1'b1}},
    // 3x2 image, 2x4 cells: partial cells on the right and bottom
    '{ROW_CFG, CFG_IMAGE_WIDTH,  13'd3, 8'd0, 1'b0, 1'b0, NO_WORD},
    '{ROW_CFG, CFG_IMAGE_HEIGHT, 13'd2, 8'd0, 1'b0, 1'b0, NO_WORD},
    '{ROW_CFG, CFG_CELL_SCALE,   13'd2, 8'd0, 1'b0, 1'b0, NO_WORD},
    '{ROW_PIX, CFG_IMAGE_WIDTH, 13'd0, 8'd10,  1'b1, 1'b0, NO_WORD},
    '{ROW_PIX, CFG_IMAGE_WIDTH, 13'd0, 8'd20,  1'b0, 1'b0, NO_WORD},
    '{ROW_PIX, CFG_IMAGE_WIDTH, 13'd0, 8'd30,  1'b0, 1'b0, NO_WORD},
    '{ROW_PIX, CFG_IMAGE_WIDTH, 13'd0, 8'd40,  1'b0, 1'b0, NO_WORD},
    '{ROW_PIX, CFG_IMAGE_WIDTH, 13'd0, 8'd50,  1'b0, 1'b0, NO_WORD},
    '{ROW_PIX, CFG_IMAGE_WIDTH, 13'd0, 8'd60,  1'b0, 1'b0, NO_WORD},
    // restart the frame in the middle of a row
    '{ROW_PIX, CFG_IMAGE_WIDTH, 13'd0, 8'd200, 1'b0, 1'b0, NO_WORD},
    '{ROW_PIX, CFG_IMAGE_WIDTH, 13'd0, 8'd100, 1'b1, 1'b0, NO_WORD},
    '{ROW_PIX, CFG_IMAGE_WIDTH, 13'd0, 8'd7,   1'b0, 1'b0, NO_WORD},
    // shrink the width under the current column: next pixel opens a new row
    '{ROW_CFG, CFG_IMAGE_WIDTH,  13'd1, 8'd0, 1'b0, 1'b0, NO_WORD},
    '{ROW_PIX, CFG_IMAGE_WIDTH, 13'd0, 8'd33,  1'b0, 1'b0, NO_WORD},
    // grow the height, then shrink it under the current row: the next pixel wraps to row 0
    '{ROW_CFG, CFG_IMAGE_HEIGHT, 13'd4, 8'd0, 1'b0, 1'b0, NO_WORD},
    '{ROW_PIX, CFG_IMAGE_WIDTH, 13'd0, 8'd5,   1'b0, 1'b0, NO_WORD},
    '{ROW_PIX, CFG_IMAGE_WIDTH, 13'd0, 8'd6,   1'b0, 1'b0, NO_WORD},
    '{ROW_PIX, CFG_IMAGE_WIDTH, 13'd0, 8'd7,   1'b0, 1'b0, NO_WORD},
    '{ROW_CFG, CFG_IMAGE_HEIGHT, 13'd2, 8'd0, 1'b0, 1'b0, NO_WORD},
    '{ROW_PIX, CFG_IMAGE_WIDTH, 13'd0, 8'd8,   1'b0, 1'b0, NO_WORD},
    '{ROW_PIX, CFG_IMAGE_WIDTH, 13'd0, 8'd9,   1'b0, 1'b0, NO_WORD}
  };

  function automatic int unsigned span(input logic [12:0] v, input int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  // Advance the mirror by one pixel; returns 1 when the pixel closes a cell.
  function automatic bit average_cell(input logic [PIXEL_W-1:0] px, input logic fs,
                                      output glyph_word_t word);
    int unsigned wd, ht, sc, band, x, y, cx, cic, rib, total, avg, gi;
    bit hit;
    wd = span(width_reg, 4096);
    ht = span(height_reg, 4096);
    sc = span(13'(scale_reg), 8);
    band = 2 * sc;
    hit = 1'b0;
    word = '0;
    if (fs) begin
      at_x = '0;
      at_y = '0;
      row_acc = '0;
    end
    if (at_x >= wd) begin
      at_x = '0;
      at_y = at_y + 13'd1;
    end
    if (at_y >= ht) at_y = '0;
    x = at_x;
    y = at_y;
    cx = x / sc;
    cic = x % sc;
    rib = y % band;
    if (cic == 0) row_acc = '0;
    row_acc = row_acc + 15'(px);
    if (cic == sc - 1 || x == wd - 1) begin
      total = (rib == 0 ? 0 : int'(band_sums[cx])) + row_acc;
      band_sums[cx] = 15'(total);
      if (rib == band - 1 || y == ht - 1) begin
        avg = total / ((cic + 1) * (rib + 1));
        gi = avg * 9 / 255;
        if (gi > 9) gi = 9;
        word.glyph       = 7'(glyph_set[gi]);
        word.cell_column = 12'(cx);
        word.cell_row    = 11'(y / band);
        word.line_end    = (x == wd - 1);
        word.frame_end   = (x == wd - 1) && (y == ht - 1);
        hit = 1'b1;
      end
    end
    x++;
    if (x >= wd) begin
      x = 0;
      y++;
      if (y >= ht) y = 0;
    end
    at_x = 13'(x);
    at_y = 13'(y);
    return hit;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [PIXEL_W-1:0] pick_luma(input luma_mode_t mode,
                                                   input logic [PIXEL_W-1:0] base);
    int v;
    case (mode)
      LUMA_NOISE: return 8'($urandom_range(0, 255));
      LUMA_RAILS: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      LUMA_FLAT:  return base;
      default: begin
        v = int'(base) + int'($urandom_range(0, 2)) - 1;
        if (v > 255) v = 255;
        return 8'(v);
      end
    endcase
  endfunction

  task automatic push_pixel(input logic [PIXEL_W-1:0] px, input logic fs,
                            input logic known, input glyph_word_t want);
    glyph_word_t got;
    bit          emits;
    int          gap;
    in_valid       <= 1'b1;
    in_pixel       <= px;
    in_frame_start <= fs;
    do @(posedge clk); while (in_stall);
    pixels_sent++;
    emits = average_cell(px, fs, got);
    if (known) glyphs_due.push_back(want);
    else if (emits) glyphs_due.push_back(got);
    if (!quiet) begin
      if ($urandom_range(0, 249) == 0) begin
        // hold off until the pipeline has drained
        in_valid <= 1'b0;
        @(posedge clk);
        while (glyphs_due.size() != 0) @(posedge clk);
      end else begin
        gap = idle_len();
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [DIM_W-1:0] val);
    in_valid <= 1'b0;
    while (glyphs_due.size() != 0) @(posedge clk);
    // cells that close no word may still be in flight
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_IMAGE_WIDTH:  width_reg = val;
      CFG_IMAGE_HEIGHT: height_reg = val;
      CFG_CELL_SCALE:   scale_reg = val[SCALE_W-1:0];
      default: ;
    endcase
    settings_seen++;
  endtask

  // Stream whole frames; the last one is cut to 'cut' pixels when cut is nonzero and below the frame size.
  task automatic run_frames(input int frames, input bit noisy, input int cut);
    int          npix, n, k;
    luma_mode_t  mode;
    logic [7:0]  base;
    logic        fs;
    npix = span(width_reg, 4096) * span(height_reg, 4096);
    for (int f = 0; f < frames; f++) begin
      mode = luma_mode_t'($urandom_range(0, 3));
      base = 8'($urandom_range(0, 255));
      if (mode == LUMA_EDGE) begin
        k = $urandom_range(1, 9);
        base = 8'((k * 255 + 8) / 9);
      end
      n = (f == frames - 1 && cut > 0 && cut < npix) ? cut : npix;
      for (int i = 0; i < n; i++) begin
        fs = (i == 0) || (noisy && $urandom_range(0, 99) < 2);
        push_pixel(pick_luma(mode, base), fs, 1'b0, NO_WORD);
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fault_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (glyphs_due.size() == 0) begin
        $error("unexpected word: glyph %0d column %0d row %0d",
               out_glyph, out_cell_column, out_cell_row);
        fault_count++;
      end else begin
        due_head = glyphs_due.pop_front();
        check_field("glyph", due_head.glyph, out_glyph);
        check_field("cell_column", due_head.cell_column, out_cell_column);
        check_field("cell_row", due_head.cell_row, out_cell_row);
        check_field("line_end", due_head.line_end, out_line_end);
        check_field("frame_end", due_head.frame_end, out_frame_end);
        words_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (quiet) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= ($urandom_range(0, 2) == 0);
      stall_left <= idle_len();
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_CAP) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int          base_pixels, frames, cut, r;
    logic [12:0] wv, hv;
    logic [3:0]  sv;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // power-up registers: first four rows of a 240x180 frame
    run_frames(1, 1'b0, 960);

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) write_reg(script[i].idx, script[i].val);
      else push_pixel(script[i].luma, script[i].fs, script[i].known, script[i].want);
    end

    // widest row with one-pixel cells; saturated width, zero height and scale
    write_reg(CFG_IMAGE_WIDTH, 13'd8191);
    write_reg(CFG_IMAGE_HEIGHT, 13'd0);
    write_reg(CFG_CELL_SCALE, 13'd0);
    run_frames(1, 1'b0, 0);
    // tallest frame, one pixel wide
    write_reg(CFG_IMAGE_WIDTH, 13'd0);
    write_reg(CFG_IMAGE_HEIGHT, 13'd4096);
    write_reg(CFG_CELL_SCALE, 13'd1);
    run_frames(1, 1'b0, 0);

    base_pixels = pixels_sent;
    while (pixels_sent - base_pixels < RANDOM_PIXELS) begin
      r = $urandom_range(0, 99);
      wv = (r < 8) ? 13'd0 : (r < 75) ? 13'($urandom_range(1, 24)) : 13'($urandom_range(25, 80));
      r = $urandom_range(0, 99);
      hv = (r < 8) ? 13'd0 : 13'($urandom_range(1, 40));
      if (span(wv, 4096) * span(hv, 4096) > 600) hv = 13'(600 / span(wv, 4096));
      r = $urandom_range(0, 99);
      sv = (r < 20) ? 4'($urandom_range(0, 1) ? 0 : $urandom_range(9, 15))
                    : 4'($urandom_range(1, 8));
      write_reg(CFG_IMAGE_WIDTH, wv);
      write_reg(CFG_IMAGE_HEIGHT, hv);
      write_reg(CFG_CELL_SCALE, 13'(($urandom_range(0, 511) << 4) | sv));
      quiet = ($urandom_range(0, 3) == 0);
      frames = $urandom_range(1, 3);
      cut = ($urandom_range(0, 4) == 0) ?
            $urandom_range(1, span(wv, 4096) * span(hv, 4096)) : 0;
      run_frames(frames, 1'b1, cut);
    end
    quiet = 1'b0;

    in_valid <= 1'b0;
    while (glyphs_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d pixels and %0d glyph words over %0d register writes",
             pixels_sent, words_checked, settings_seen);
    $display("incl. power-up size, saturated sizes, 4096-wide and 4096-tall frames");
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
